### sv/relay_id_translation_table_assert.svh
// Assertion macros shared by the relay ID translation table modules.
// Depends on nothing; define NO_ASSERTIONS to compile them away.
`ifndef RELAY_ID_TRANSLATION_TABLE_ASSERT_SVH
`define RELAY_ID_TRANSLATION_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RITT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RITT_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RITT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define RITT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### sv/ritt_pkg.sv
// Package for the relay ID translation table: payload types, constants, commands.
// Depends on nothing.
`default_nettype none
package ritt_pkg;
    localparam int TableDepth = 256;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = IdxW + 1;
    localparam logic [15:0] LifetimeReset = 16'd10;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_CLEANUP = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_seconds;
        logic [15:0] query_client_id;
        logic [31:0] query_client_ip;
        logic [15:0] query_client_port;
        logic [15:0] target_relay_id;
    } t_in;

    typedef struct packed {
        logic        success;
        logic [7:0]  granted_relay_id;
        logic [15:0] found_client_id;
        logic [31:0] found_client_ip;
        logic [15:0] found_client_port;
        logic [8:0]  cleared_count;
    } t_out;

    typedef struct packed {
        logic [IdxW-1:0] slot;
        logic [63:0]     payload;
        logic [31:0]     expiry;
    } t_entry;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ,
        OP_WRITE,
        OP_CLEAR,
        OP_POP,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [IdxW-1:0] addr;
    } t_dp_cmd;

    typedef struct packed {
        logic [31:0]     rd_expiry;
        logic [63:0]     rd_payload;
        logic [IdxW-1:0] ring_head;
        logic [CntW-1:0] free_count;
    } t_dp_sts;
endpackage
`default_nettype wire

### sv/ritt_datapath.sv
// Datapath of the relay ID translation table: slot memory, per-slot written bits, free queue.
// Depends on ritt_pkg.
`default_nettype none
module ritt_datapath (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire ritt_pkg::t_dp_cmd  i_cmd,
    input  wire [63:0]              i_wr_payload,
    input  wire [31:0]              i_wr_expiry,
    output ritt_pkg::t_dp_sts       o_sts
);
    import ritt_pkg::*;

    // Slot contents: client id, ip, port packed in one word; expiry in another.
    logic [63:0]     r_payload_mem [TableDepth];
    logic [31:0]     r_expiry_mem  [TableDepth];
    logic [TableDepth-1:0] r_written;
    logic [IdxW-1:0] r_ring_mem [TableDepth];
    logic [IdxW-1:0] r_head, r_tail;
    logic [CntW-1:0] r_count;
    logic [63:0]     r_rd_payload;
    logic [31:0]     r_rd_expiry;
    logic            r_rd_valid;
    logic [IdxW-1:0] r_ring_rd;

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WRITE) begin
            r_payload_mem[i_cmd.addr] <= i_wr_payload;
            r_expiry_mem[i_cmd.addr]  <= i_wr_expiry;
        end
        if (i_cmd.op == OP_CLEAR) begin
            r_expiry_mem[i_cmd.addr]  <= '0;
            r_payload_mem[i_cmd.addr] <= '0;
        end
        if (i_cmd.op == OP_PUSH) begin
            r_ring_mem[r_tail] <= i_cmd.addr;
        end
        r_rd_payload <= r_payload_mem[i_cmd.addr];
        r_rd_expiry  <= r_expiry_mem[i_cmd.addr];
        r_ring_rd    <= r_ring_mem[r_head];
    end

    // Written bits stand in for the reset-time clear of the table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written  <= '0;
            r_rd_valid <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
        end else begin
            r_rd_valid <= r_written[i_cmd.addr];
            if (i_cmd.op == OP_WRITE || i_cmd.op == OP_CLEAR) begin
                r_written[i_cmd.addr] <= 1'b1;
            end
            if (i_cmd.op == OP_POP) begin
                r_head  <= r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.op == OP_PUSH) begin
                r_tail  <= r_tail + 1'b1;
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_sts.rd_expiry  = r_rd_valid ? r_rd_expiry : '0;
    assign o_sts.rd_payload = r_rd_valid ? r_rd_payload : '0;
    assign o_sts.ring_head  = r_ring_rd;
    assign o_sts.free_count = r_count;

    `include "relay_id_translation_table_assert.svh"
    `RITT_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, r_count <= CntW'(TableDepth - 1), "free count overflow")
    `RITT_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, (i_cmd.op == OP_POP) |-> (r_count != '0), "pop of empty queue")
    `RITT_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, (i_cmd.op == OP_PUSH) |-> (r_count < CntW'(TableDepth - 1)), "push to full queue")
endmodule
`default_nettype wire

### sv/ritt_ctrl.sv
// Controller of the relay ID translation table: sequences each request over the datapath.
// Depends on ritt_pkg.
`default_nettype none
module ritt_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire ritt_pkg::t_in     i_data,
    output logic                   o_valid,
    input  wire                    i_ready,
    output ritt_pkg::t_out         o_data,
    input  wire [15:0]             i_lifetime,
    output ritt_pkg::t_dp_cmd      o_dp_cmd,
    output logic [63:0]            o_wr_payload,
    output logic [31:0]            o_wr_expiry,
    input  wire ritt_pkg::t_dp_sts i_sts
);
    import ritt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RDWAIT, S_EVAL, S_RINGWAIT, S_POP, S_PUSH, S_STEP, S_DONE
    } t_state;

    t_state          r_state;
    t_in             r_req;
    t_out            r_out;
    t_dp_cmd         r_dp;
    logic [IdxW-1:0] r_scan;
    logic [CntW-1:0] r_iter;
    logic [IdxW-1:0] r_addr;
    logic [8:0]      r_cleared;

    logic [32:0]     w_sum;
    logic [31:0]     w_new_expiry;
    logic            w_target_ok;
    logic [IdxW-1:0] w_scan_next;
    logic [31:0]     w_exp;
    logic            w_take;
    logic            w_expired;

    // Expiry for a new entry, saturated to 32 bits.
    assign w_sum = {1'b0, r_req.now_seconds} + {17'd0, i_lifetime};
    assign w_new_expiry = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
    assign w_target_ok = (r_req.target_relay_id < 16'(TableDepth));
    assign w_scan_next = (r_scan == IdxW'(TableDepth - 1)) ? IdxW'(1) : r_scan + IdxW'(1);
    assign w_exp = i_sts.rd_expiry;
    assign w_take = (w_exp == '0) || (w_exp < r_req.now_seconds);
    assign w_expired = (w_exp != '0) && (w_exp < r_req.now_seconds);

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_DONE);
    assign o_data       = r_out;
    assign o_dp_cmd     = r_dp;
    assign o_wr_payload = {r_req.query_client_id, r_req.query_client_ip,
                           r_req.query_client_port};
    assign o_wr_expiry  = w_new_expiry;

    // Request sequencer: one datapath step per cycle, holding in S_DONE until the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dp    <= '{op: OP_NONE, addr: '0};
            r_scan  <= IdxW'(1);
        end else begin
            r_dp.op <= OP_NONE;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req     <= i_data;
                        r_out     <= '0;
                        r_iter    <= '0;
                        r_cleared <= '0;
                        case (t_cmd'(i_data.cmd))
                            CMD_ALLOC: begin
                                if (i_sts.free_count != '0) begin
                                    r_state <= S_RINGWAIT;
                                end else begin
                                    r_dp.addr <= r_scan;
                                    r_addr    <= r_scan;
                                    r_scan    <= w_scan_next;
                                    r_state   <= S_RDWAIT;
                                end
                            end
                            CMD_CLEANUP: begin
                                r_dp.addr <= '0;
                                r_addr    <= '0;
                                r_state   <= S_RDWAIT;
                            end
                            default: begin
                                r_dp.addr <= i_data.target_relay_id[IdxW-1:0];
                                r_addr    <= i_data.target_relay_id[IdxW-1:0];
                                r_state   <= S_RDWAIT;
                            end
                        endcase
                    end
                end
                S_RINGWAIT: begin
                    // The ring head was read last cycle; write the slot it names.
                    r_dp.op   <= OP_WRITE;
                    r_dp.addr <= i_sts.ring_head;
                    r_out.success          <= 1'b1;
                    r_out.granted_relay_id <= 8'(i_sts.ring_head);
                    r_state   <= S_POP;
                end
                S_POP: begin
                    // Drop the used entry from the queue after the slot write.
                    r_dp.op <= OP_POP;
                    r_state <= S_DONE;
                end
                S_PUSH: begin
                    // Queue the released slot after its clear.
                    r_dp.op   <= OP_PUSH;
                    r_dp.addr <= r_addr;
                    r_state   <= S_DONE;
                end
                S_STEP: begin
                    // Cleanup moves on to the next slot once the clear is done.
                    r_dp.addr <= r_addr + IdxW'(1);
                    r_addr    <= r_addr + IdxW'(1);
                    r_state   <= S_RDWAIT;
                end
                S_RDWAIT: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_state <= S_DONE;
                    case (t_cmd'(r_req.cmd))
                        CMD_ALLOC: begin
                            if (w_take) begin
                                r_dp.op   <= OP_WRITE;
                                r_dp.addr <= r_addr;
                                r_out.success          <= 1'b1;
                                r_out.granted_relay_id <= 8'(r_addr);
                            end else if (r_iter != CntW'(TableDepth - 1)) begin
                                r_iter    <= r_iter + CntW'(1);
                                r_dp.addr <= r_scan;
                                r_addr    <= r_scan;
                                r_scan    <= w_scan_next;
                                r_state   <= S_RDWAIT;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (w_target_ok && w_exp >= r_req.now_seconds) begin
                                r_out.success           <= 1'b1;
                                r_out.found_client_id   <= i_sts.rd_payload[63:48];
                                r_out.found_client_ip   <= i_sts.rd_payload[47:16];
                                r_out.found_client_port <= i_sts.rd_payload[15:0];
                            end
                        end
                        CMD_RELEASE: begin
                            if (w_target_ok && w_exp != '0) begin
                                r_out.success <= 1'b1;
                                r_dp.op   <= OP_CLEAR;
                                r_dp.addr <= r_addr;
                                if (i_sts.free_count < CntW'(TableDepth - 1)) begin
                                    r_state <= S_PUSH;
                                end
                            end
                        end
                        default: begin
                            if (w_expired) begin
                                r_dp.op   <= OP_CLEAR;
                                r_dp.addr <= r_addr;
                                r_cleared <= r_cleared + 9'd1;
                            end
                            if (r_addr == IdxW'(TableDepth - 1)) begin
                                r_out.cleared_count <= r_cleared + 9'(w_expired);
                            end else if (w_expired) begin
                                r_state <= S_STEP;
                            end else begin
                                r_dp.addr <= r_addr + IdxW'(1);
                                r_addr    <= r_addr + IdxW'(1);
                                r_state   <= S_RDWAIT;
                            end
                        end
                    endcase
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "relay_id_translation_table_assert.svh"
    `RITT_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid, "result dropped")
    `RITT_ASSERT_IMPL(a_ready_excl, i_clk, i_rst_n, !(o_ready && o_valid), "ready with result")
    `RITT_ASSERT_IMPL(a_pop_order, i_clk, i_rst_n, (r_dp.op == OP_POP) |-> o_valid, "pop out of order")
    `RITT_ASSERT_NORST(a_scan_nz, i_clk, i_rst_n |-> (r_scan != '0), "scan pointer at zero")
endmodule
`default_nettype wire

### sv/relay_id_translation_table.sv
// Relay ID translation table: maps client query IDs to relay slot IDs with expiry.
// Takes one request at a time: o_ready is high only while the block is idle, and a result
// waits in an output register until it is taken. An allocate from the free queue writes the
// slot at the queue head; one that scans tries slots in turn, up to 256 tries, and cleanup
// visits every slot. A release queues its slot only while the free queue has room. This
// sequencing is set by the single-port slot memory with a registered read.
// Unwritten slots read as empty through per-slot written bits, so there is no clearing
// pass after reset. Depends on ritt_pkg, ritt_ctrl, ritt_datapath.
`default_nettype none
module relay_id_translation_table (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire ritt_pkg::t_in i_data,
    output logic               o_valid,
    input  wire                i_ready,
    output ritt_pkg::t_out     o_data,
    input  wire                i_cfg_we,
    input  wire [15:0]         i_cfg_data
);
    import ritt_pkg::*;

    logic [15:0] r_lifetime;
    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;
    logic [63:0] w_payload;
    logic [31:0] w_expiry;

    // Lifetime register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= LifetimeReset;
        end else if (i_cfg_we) begin
            r_lifetime <= i_cfg_data;
        end
    end

    ritt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data),
        .i_lifetime   (r_lifetime),
        .o_dp_cmd     (w_cmd),
        .o_wr_payload (w_payload),
        .o_wr_expiry  (w_expiry),
        .i_sts        (w_sts)
    );

    ritt_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_wr_payload (w_payload),
        .i_wr_expiry  (w_expiry),
        .o_sts        (w_sts)
    );
endmodule
`default_nettype wire

### tb/sv/relay_id_translation_table_tb.sv
// Testbench for the relay ID translation table: random and directed requests
// checked against a behavioral table model. Depends on ritt_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module relay_id_translation_table_tb;
    import ritt_pkg::*;

    localparam int Depth = TableDepth;
    localparam int CycleLimit = 4000000;

    // Behavioral model of the table and the checker of its responses.
    class relay_table_scoreboard;
        logic [15:0] lifetime;
        logic [15:0] ent_id[Depth];
        logic [31:0] ent_ip[Depth];
        logic [15:0] ent_port[Depth];
        logic [31:0] ent_exp[Depth];
        logic [7:0]  ring[Depth];
        int head, tail, count, scan;
        t_out pending[$];
        int mismatches;
        int checked;

        function new();
            lifetime = LifetimeReset;
            for (int i = 0; i < Depth; i++) begin
                ent_id[i] = 0; ent_ip[i] = 0; ent_port[i] = 0; ent_exp[i] = 0; ring[i] = 0;
            end
            head = 0; tail = 0; count = 0; scan = 1;
            mismatches = 0; checked = 0;
        endfunction

        function void fill(int s, t_in req);
            logic [32:0] sum;
            sum = {1'b0, req.now_seconds} + {17'd0, lifetime};
            ent_id[s] = req.query_client_id;
            ent_ip[s] = req.query_client_ip;
            ent_port[s] = req.query_client_port;
            ent_exp[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        endfunction

        function void clear(int s);
            ent_id[s] = 0; ent_ip[s] = 0; ent_port[s] = 0; ent_exp[s] = 0;
        endfunction

        // Works out the response to one accepted request.
        function void note_request(t_in req);
            t_out r;
            int s;
            r = '0;
            case (t_cmd'(req.cmd))
                CMD_ALLOC: begin
                    if (count > 0) begin
                        s = ring[head];
                        head = (head + 1) % Depth;
                        count--;
                        fill(s, req);
                        r.success = 1; r.granted_relay_id = 8'(s);
                    end else begin
                        for (int i = 0; i < Depth; i++) begin
                            s = scan % Depth;
                            scan = (scan % (Depth - 1)) + 1;
                            if (ent_exp[s] == 0 || ent_exp[s] < req.now_seconds) begin
                                fill(s, req);
                                r.success = 1; r.granted_relay_id = 8'(s);
                                break;
                            end
                        end
                    end
                end
                CMD_LOOKUP: begin
                    if (req.target_relay_id < Depth &&
                        ent_exp[req.target_relay_id] >= req.now_seconds) begin
                        r.success = 1;
                        r.found_client_id = ent_id[req.target_relay_id];
                        r.found_client_ip = ent_ip[req.target_relay_id];
                        r.found_client_port = ent_port[req.target_relay_id];
                    end
                end
                CMD_RELEASE: begin
                    if (req.target_relay_id < Depth && ent_exp[req.target_relay_id] > 0) begin
                        clear(req.target_relay_id);
                        if (count < Depth - 1) begin
                            ring[tail] = req.target_relay_id[7:0];
                            tail = (tail + 1) % Depth;
                            count++;
                        end
                        r.success = 1;
                    end
                end
                default: begin
                    for (int i = 0; i < Depth; i++)
                        if (ent_exp[i] > 0 && ent_exp[i] < req.now_seconds) begin
                            clear(i);
                            r.cleared_count++;
                        end
                end
            endcase
            pending.push_back(r);
        endfunction

        // Compares one response with the oldest one predicted.
        function void check_response(t_out got);
            t_out want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected response %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.success !== want.success || got.granted_relay_id !== want.granted_relay_id ||
                got.found_client_id !== want.found_client_id ||
                got.found_client_ip !== want.found_client_ip ||
                got.found_client_port !== want.found_client_port ||
                got.cleared_count !== want.cleared_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %h, got %h", want, got);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, i_ready, i_cfg_we;
    logic o_ready, o_valid;
    t_in i_data;
    t_out o_data;
    logic [15:0] i_cfg_data;

    relay_table_scoreboard board;
    int cycles;
    int sent;
    int hold_off;
    bit no_idle;
    logic [31:0] clock_now;

    relay_id_translation_table u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle counter with a watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles", cycles);
            $display("relay_id_translation_table_tb NOT OK");
            $finish;
        end
    end

    // Response side: samples each transfer and stalls at random or on a hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_response(o_data);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= no_idle || ($urandom_range(99) >= 9);
        end
    end

    // Sends one request and waits for its transfer.
    task automatic send_request(t_in req);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 9) @(negedge i_clk);
        i_data <= req;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_request(req);
        sent++;
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic send_cmd(t_cmd c, logic [31:0] now_s, logic [15:0] target);
        t_in req;
        req.cmd = c;
        req.now_seconds = now_s;
        req.query_client_id = 16'($urandom);
        req.query_client_ip = $urandom;
        req.query_client_port = 16'($urandom);
        req.target_relay_id = target;
        send_request(req);
    endtask

    // Waits until the table is idle, then writes the lifetime.
    task automatic set_lifetime(logic [15:0] value);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (2 * Depth + 20) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        board.lifetime = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random phase: mostly allocates and lookups of random slots, advancing time.
    task automatic random_phase(int n);
        int r;
        logic [15:0] tgt;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            clock_now = clock_now + $urandom_range(3);
            if ($urandom_range(9) == 0) tgt = 16'($urandom);
            else tgt = 16'($urandom_range(Depth - 1));
            if (r < 40) send_cmd(CMD_ALLOC, clock_now, tgt);
            else if (r < 70) send_cmd(CMD_LOOKUP, clock_now, tgt);
            else if (r < 95) send_cmd(CMD_RELEASE, clock_now, tgt);
            else send_cmd(CMD_CLEANUP, clock_now, tgt);
        end
    endtask

    initial begin
        board = new();
        sent = 0; hold_off = 0; no_idle = 0;
        i_rst_n = 0; i_valid = 0; i_data = '0; i_cfg_we = 0; i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-slot lookup at time zero, range checks, extremes.
        send_cmd(CMD_LOOKUP, 32'd0, 16'd5);
        send_cmd(CMD_LOOKUP, 32'd1, 16'd5);
        send_cmd(CMD_RELEASE, 32'd1, 16'd5);
        send_cmd(CMD_LOOKUP, 32'd0, 16'hFFFF);
        send_cmd(CMD_RELEASE, 32'd0, 16'd256);
        send_cmd(CMD_ALLOC, 32'd100, 16'd0);
        send_cmd(CMD_ALLOC, 32'hFFFF_FFF0, 16'd0);
        send_cmd(CMD_LOOKUP, 32'd110, 16'd1);
        send_cmd(CMD_LOOKUP, 32'd111, 16'd1);
        send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 16'd2);
        send_cmd(CMD_RELEASE, 32'd0, 16'd2);
        send_cmd(CMD_ALLOC, 32'd0, 16'd0);
        send_cmd(CMD_CLEANUP, 32'd110, 16'd0);
        send_cmd(CMD_CLEANUP, 32'd111, 16'd0);
        send_cmd(CMD_CLEANUP, 32'hFFFF_FFFF, 16'hFFFF);

        // Long lifetime: exhaust the table, then release until the queue is full.
        set_lifetime(16'hFFFF);
        no_idle = 1;
        for (int i = 0; i < Depth + 2; i++) send_cmd(CMD_ALLOC, 32'd1000, 16'd0);
        no_idle = 0;
        for (int i = 1; i < Depth; i++) send_cmd(CMD_RELEASE, 32'd1000, i[15:0]);
        send_cmd(CMD_ALLOC, 32'd1000, 16'd0);
        send_cmd(CMD_RELEASE, 32'd1000, 16'd3);
        send_cmd(CMD_CLEANUP, 32'hFFFF_FFFF, 16'd0);

        // Receiver holds off while requests keep coming.
        hold_off = 400;
        clock_now = 2000;
        random_phase(40);

        // Zero lifetime sets the expiry of each allocated slot to the request time.
        set_lifetime(16'd0);
        random_phase(30);

        set_lifetime(16'd1);
        clock_now = 32'hFFFF_FF00;
        random_phase(40);

        set_lifetime(16'd10);
        clock_now = 5000;
        random_phase(80);
        no_idle = 1;
        random_phase(40);
        no_idle = 0;

        set_lifetime(16'd40);
        random_phase(40);

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (2 * Depth + 20) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d responses over five lifetimes,",
                 sent, board.checked);
        $display("including table exhaustion, a full release queue and output back-pressure.");
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("relay_id_translation_table_tb OK");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("relay_id_translation_table_tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
+incdir+sv
sv/ritt_pkg.sv
sv/ritt_datapath.sv
sv/ritt_ctrl.sv
sv/relay_id_translation_table.sv
tb/sv/relay_id_translation_table_tb.sv
